// ----- rtl/asn1_time_to_epoch_parser_defines.svh -----
`ifndef ASN1_TIME_TO_EPOCH_PARSER_DEFINES_SVH
`define ASN1_TIME_TO_EPOCH_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define A2E_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define A2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/a2e_pkg.sv -----
`default_nettype none

package a2e_pkg;

    // port and field widths
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned EPOCH_W   = 40;
    localparam int unsigned MILLI_W   = 10;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned FIELD_W   = 7;
    localparam int unsigned ROW_W     = 4;
    localparam int unsigned DOY_W     = 9;
    localparam int unsigned Q100_W    = 8;
    localparam int unsigned TODP_W    = 19;
    localparam int unsigned TZ_W      = 20;
    localparam int unsigned TOD_W     = 21;
    localparam int unsigned DAYS_W    = 24;
    localparam int unsigned FLD_W     = 5;

    // string kinds
    localparam logic [KIND_W-1:0] KIND_GEN = 2'd1;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ZULU  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    // field update codes
    localparam logic [FLD_W-1:0] FLD_NONE      = 5'd0;
    localparam logic [FLD_W-1:0] FLD_YEAR_INIT = 5'd1;
    localparam logic [FLD_W-1:0] FLD_YEAR_ACC  = 5'd2;
    localparam logic [FLD_W-1:0] FLD_MON_HI    = 5'd3;
    localparam logic [FLD_W-1:0] FLD_MON_LO    = 5'd4;
    localparam logic [FLD_W-1:0] FLD_DAY_HI    = 5'd5;
    localparam logic [FLD_W-1:0] FLD_DAY_LO    = 5'd6;
    localparam logic [FLD_W-1:0] FLD_HOUR_HI   = 5'd7;
    localparam logic [FLD_W-1:0] FLD_HOUR_LO   = 5'd8;
    localparam logic [FLD_W-1:0] FLD_MIN_HI    = 5'd9;
    localparam logic [FLD_W-1:0] FLD_MIN_LO    = 5'd10;
    localparam logic [FLD_W-1:0] FLD_SEC_HI    = 5'd11;
    localparam logic [FLD_W-1:0] FLD_SEC_LO    = 5'd12;
    localparam logic [FLD_W-1:0] FLD_MS_INIT   = 5'd13;
    localparam logic [FLD_W-1:0] FLD_MS_ACC    = 5'd14;
    localparam logic [FLD_W-1:0] FLD_SIGN      = 5'd15;
    localparam logic [FLD_W-1:0] FLD_OH_HI     = 5'd16;
    localparam logic [FLD_W-1:0] FLD_OH_LO     = 5'd17;
    localparam logic [FLD_W-1:0] FLD_OM_HI     = 5'd18;
    localparam logic [FLD_W-1:0] FLD_OM_LO     = 5'd19;

    // calendar constants
    localparam logic [YEAR_W-1:0]  UTC_PIVOT      = 14'd70;
    localparam logic [YEAR_W-1:0]  CENTURY_20     = 14'd2000;
    localparam logic [YEAR_W-1:0]  CENTURY_19     = 14'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_BIAS      = 14'd400;
    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR  = 24'd365;
    // 719468 (civil epoch) + 146097 (one era of bias) + 1 (day is one-based)
    localparam logic [DAYS_W-1:0]  DAYS_BIAS      = 24'd865566;
    localparam logic [TODP_W-1:0]  SEC_PER_HOUR   = 19'd3600;
    localparam logic [TODP_W-1:0]  SEC_PER_MIN    = 19'd60;
    localparam logic signed [EPOCH_W-1:0] SEC_PER_DAY = 40'sd86400;
    localparam logic [MILLI_W-1:0] MILLI_MAX      = 10'd999;

    // x / 12 as (x * 43) >> 9, exact for x below 128
    localparam int unsigned        RECIP12_W      = 13;
    localparam logic [RECIP12_W-1:0] RECIP_12     = 13'd43;
    localparam int unsigned        RECIP12_SHIFT  = 9;
    // y / 100 as (y * 5243) >> 19, exact for y below 43690
    localparam int unsigned        RECIP100_W     = 27;
    localparam logic [RECIP100_W-1:0] RECIP_100   = 27'd5243;
    localparam int unsigned        RECIP100_SHIFT = 19;

    // character class from the datapath
    typedef struct packed {
        logic is_digit;
        logic is_zulu;
        logic is_plus;
        logic is_minus;
        logic is_dot;
    } a2e_status_t;

    // commands to the datapath
    typedef struct packed {
        logic [FLD_W-1:0] fld;
        logic             kind_gen;
        logic             cv1;
        logic             cv2;
        logic             cv3;
        logic             cv4;
        logic             out_load;
        logic             out_ok;
    } a2e_cmd_t;

    // digit times ten
    function automatic logic [FIELD_W-1:0] times_ten(input logic [DIGIT_W-1:0] d);
        logic [FIELD_W-1:0] w;
        w = FIELD_W'(d);
        return (w << 3) + (w << 1);
    endfunction

    // days before the month in a march-based year, by zero-based month
    function automatic logic [DOY_W-1:0] month_doy(input logic [ROW_W-1:0] row);
        logic [DOY_W-1:0] v;
        unique case (row)
            4'd0:    v = 9'd306;
            4'd1:    v = 9'd337;
            4'd2:    v = 9'd0;
            4'd3:    v = 9'd31;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd92;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd153;
            4'd8:    v = 9'd184;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd245;
            4'd11:   v = 9'd275;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/asn1_time_to_epoch_parser.sv -----
// certificate time string to unix seconds, one character per word
// result: the word of a rejected string is registered as its last character is taken,
//   that of a good string after the conversion states ST_CV1 to ST_CV5
// throughput: one character per cycle unless a result word is stalled; after a good
//   string the five-step calendar conversion holds s_tready low until its word is loaded
// reset: aresetn low, synchronous, restarts the parser and drops a pending result word

`default_nettype none

module asn1_time_to_epoch_parser (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [a2e_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] char_byte
    input  wire  [a2e_pkg::KIND_W-1:0]        s_tuser,   // [1:0] time_kind
    input  wire                               s_tlast,   // last
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [a2e_pkg::M_TDATA_W-1:0]     m_tdata,   // [39:0] epoch_seconds,
                                                         // [49:40] millis, [55:50] zero
    output logic [0:0]                        m_tuser    // [0] valid_res
);

    a2e_pkg::a2e_cmd_t                  cmd;
    a2e_pkg::a2e_status_t               status;
    logic signed [a2e_pkg::EPOCH_W-1:0] epoch_seconds;
    logic [a2e_pkg::MILLI_W-1:0]        millis;
    logic                               valid_res;

    // grammar and sequencing
    a2e_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // fields, conversion and output word
    a2e_dpath u_dpath (
        .aclk          (aclk),
        .char_byte     (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .epoch_seconds (epoch_seconds),
        .millis        (millis),
        .valid_res     (valid_res)
    );

    // pack result word
    assign m_tdata = {(a2e_pkg::M_TDATA_W - a2e_pkg::EPOCH_W - a2e_pkg::MILLI_W)'(0),
                      millis, epoch_seconds};
    assign m_tuser = valid_res;

endmodule

`default_nettype wire

// ----- rtl/a2e_ctrl.sv -----
`default_nettype none

module a2e_ctrl (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [a2e_pkg::KIND_W-1:0]       s_tuser,
    input  wire                              s_tlast,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    input  a2e_pkg::a2e_status_t             status,
    output a2e_pkg::a2e_cmd_t                cmd
);

    // parse phases
    localparam logic [4:0] PH_START = 5'd0;
    localparam logic [4:0] PH_Y2    = 5'd1;
    localparam logic [4:0] PH_Y3    = 5'd2;
    localparam logic [4:0] PH_Y4    = 5'd3;
    localparam logic [4:0] PH_MO1   = 5'd4;
    localparam logic [4:0] PH_MO2   = 5'd5;
    localparam logic [4:0] PH_D1    = 5'd6;
    localparam logic [4:0] PH_D2    = 5'd7;
    localparam logic [4:0] PH_H1    = 5'd8;
    localparam logic [4:0] PH_H2    = 5'd9;
    localparam logic [4:0] PH_AH    = 5'd10;
    localparam logic [4:0] PH_MI2   = 5'd11;
    localparam logic [4:0] PH_AM    = 5'd12;
    localparam logic [4:0] PH_S2    = 5'd13;
    localparam logic [4:0] PH_AS    = 5'd14;
    localparam logic [4:0] PH_F1    = 5'd15;
    localparam logic [4:0] PH_F2    = 5'd16;
    localparam logic [4:0] PH_F3    = 5'd17;
    localparam logic [4:0] PH_TZ    = 5'd18;
    localparam logic [4:0] PH_OH1   = 5'd19;
    localparam logic [4:0] PH_OH2   = 5'd20;
    localparam logic [4:0] PH_OM1   = 5'd21;
    localparam logic [4:0] PH_OM2   = 5'd22;
    localparam logic [4:0] PH_DONE  = 5'd23;

    // sequencer states
    localparam logic [2:0] ST_PARSE = 3'd0;
    localparam logic [2:0] ST_CV1   = 3'd1;
    localparam logic [2:0] ST_CV2   = 3'd2;
    localparam logic [2:0] ST_CV3   = 3'd3;
    localparam logic [2:0] ST_CV4   = 3'd4;
    localparam logic [2:0] ST_CV5   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] phase_reg, phase_next;
    logic       err_reg, err_next;
    logic       kind_gen_reg, kind_gen_next;
    logic       out_valid_reg, out_valid_next;

    logic                          accept;
    logic                          out_free;
    logic                          parse_ok;
    logic [4:0]                    ph_c;
    logic                          err_c;
    logic                          kg_c;
    logic [a2e_pkg::FLD_W-1:0]     fld_c;
    logic                          dig_phase;
    logic [a2e_pkg::FLD_W-1:0]     dig_fld;
    logic [4:0]                    dig_ph;
    logic                          do_zone;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_PARSE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // grammar step for one character
    always_comb begin
        ph_c      = phase_reg;
        err_c     = err_reg;
        kg_c      = kind_gen_reg;
        fld_c     = a2e_pkg::FLD_NONE;
        dig_phase = 1'b0;
        dig_fld   = a2e_pkg::FLD_NONE;
        dig_ph    = phase_reg;
        do_zone   = 1'b0;
        if (accept && !err_reg) begin
            unique case (phase_reg)
                PH_START: begin
                    if (s_tuser[1] || !status.is_digit) begin
                        err_c = 1'b1;
                    end else begin
                        kg_c  = (s_tuser == a2e_pkg::KIND_GEN);
                        fld_c = a2e_pkg::FLD_YEAR_INIT;
                        ph_c  = PH_Y2;
                    end
                end
                PH_AH: begin
                    if (status.is_digit) begin
                        fld_c = a2e_pkg::FLD_MIN_HI;
                        ph_c  = PH_MI2;
                    end else if (kind_gen_reg) begin
                        do_zone = 1'b1;
                    end else begin
                        err_c = 1'b1;
                    end
                end
                PH_AM: begin
                    if (status.is_digit) begin
                        fld_c = a2e_pkg::FLD_SEC_HI;
                        ph_c  = PH_S2;
                    end else begin
                        do_zone = 1'b1;
                    end
                end
                PH_AS: begin
                    if (kind_gen_reg && status.is_dot) begin
                        ph_c = PH_F1;
                    end else begin
                        do_zone = 1'b1;
                    end
                end
                PH_TZ:   do_zone = 1'b1;
                PH_DONE: ;
                PH_Y2: begin
                    dig_phase = 1'b1;
                    dig_fld   = a2e_pkg::FLD_YEAR_ACC;
                    dig_ph    = kind_gen_reg ? PH_Y3 : PH_MO1;
                end
                PH_Y3:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_YEAR_ACC; dig_ph = PH_Y4;   end
                PH_Y4:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_YEAR_ACC; dig_ph = PH_MO1;  end
                PH_MO1: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MON_HI;   dig_ph = PH_MO2;  end
                PH_MO2: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MON_LO;   dig_ph = PH_D1;   end
                PH_D1:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_DAY_HI;   dig_ph = PH_D2;   end
                PH_D2:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_DAY_LO;   dig_ph = PH_H1;   end
                PH_H1:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_HOUR_HI;  dig_ph = PH_H2;   end
                PH_H2:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_HOUR_LO;  dig_ph = PH_AH;   end
                PH_MI2: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MIN_LO;   dig_ph = PH_AM;   end
                PH_S2:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_SEC_LO;   dig_ph = PH_AS;   end
                PH_F1:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MS_INIT;  dig_ph = PH_F2;   end
                PH_F2:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MS_ACC;   dig_ph = PH_F3;   end
                PH_F3:  begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_MS_ACC;   dig_ph = PH_TZ;   end
                PH_OH1: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_OH_HI;    dig_ph = PH_OH2;  end
                PH_OH2: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_OH_LO;    dig_ph = PH_OM1;  end
                PH_OM1: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_OM_HI;    dig_ph = PH_OM2;  end
                PH_OM2: begin dig_phase = 1'b1; dig_fld = a2e_pkg::FLD_OM_LO;    dig_ph = PH_DONE; end
                default: err_c = 1'b1;
            endcase

            // phases that take a digit only
            if (dig_phase) begin
                if (status.is_digit) begin
                    fld_c = dig_fld;
                    ph_c  = dig_ph;
                end else begin
                    err_c = 1'b1;
                end
            end

            // zulu on the last character, or a sign that opens the offset
            if (do_zone) begin
                if (status.is_zulu && s_tlast) begin
                    ph_c = PH_DONE;
                end else if ((status.is_plus || status.is_minus) && !s_tlast) begin
                    fld_c = a2e_pkg::FLD_SIGN;
                    ph_c  = PH_OH1;
                end else begin
                    err_c = 1'b1;
                end
            end
        end
    end

    // string complete: full form, or a generalized string cut after an optional part
    assign parse_ok = !err_c && ((ph_c == PH_DONE) ||
                      (kg_c && ((ph_c == PH_AH) || (ph_c == PH_AM) ||
                                (ph_c == PH_AS) || (ph_c == PH_TZ))));

    // sequencer and commands
    always_comb begin
        state_next     = state_reg;
        phase_next     = ph_c;
        err_next       = err_c;
        kind_gen_next  = kg_c;
        out_valid_next = out_valid_reg;

        cmd          = '0;
        cmd.fld      = fld_c;
        cmd.kind_gen = kind_gen_reg;

        unique case (state_reg)
            ST_PARSE: begin
                if (accept && s_tlast) begin
                    phase_next = PH_START;
                    err_next   = 1'b0;
                    if (parse_ok) begin
                        state_next = ST_CV1;
                    end else begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            ST_CV1: begin cmd.cv1 = 1'b1; state_next = ST_CV2; end
            ST_CV2: begin cmd.cv2 = 1'b1; state_next = ST_CV3; end
            ST_CV3: begin cmd.cv3 = 1'b1; state_next = ST_CV4; end
            ST_CV4: begin cmd.cv4 = 1'b1; state_next = ST_CV5; end
            ST_CV5: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = 1'b1;
                    state_next   = ST_PARSE;
                end
            end
            default: state_next = ST_PARSE;
        endcase

        // output word valid
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_PARSE;
            phase_reg     <= PH_START;
            err_reg       <= 1'b0;
            kind_gen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            kind_gen_reg  <= kind_gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/a2e_dpath.sv -----
`default_nettype none

module a2e_dpath (
    input  wire                                aclk,
    input  wire  [a2e_pkg::CHAR_W-1:0]         char_byte,
    input  a2e_pkg::a2e_cmd_t                  cmd,
    output a2e_pkg::a2e_status_t               status,
    output logic signed [a2e_pkg::EPOCH_W-1:0] epoch_seconds,
    output logic [a2e_pkg::MILLI_W-1:0]        millis,
    output logic                               valid_res
);

    localparam int unsigned FW = a2e_pkg::FIELD_W;

    logic [a2e_pkg::DIGIT_W-1:0] digit;

    // calendar fields
    logic [a2e_pkg::YEAR_W-1:0]  year_reg;
    logic [FW-1:0]               month_reg;
    logic [FW-1:0]               day_reg;
    logic [FW-1:0]               hour_reg;
    logic [FW-1:0]               minute_reg;
    logic [FW-1:0]               second_reg;
    logic [a2e_pkg::MILLI_W-1:0] milli_reg;
    logic                        neg_reg;
    logic [FW-1:0]               oh_reg;
    logic [FW-1:0]               om_reg;

    // conversion stages
    logic [a2e_pkg::YEAR_W-1:0]         y_reg, y_next;
    logic [a2e_pkg::DOY_W-1:0]          doy_reg, doy_next;
    logic [a2e_pkg::TODP_W-1:0]         tod_pos_reg, tod_pos_next;
    logic [a2e_pkg::Q100_W-1:0]         q100_reg, q100_next;
    logic signed [a2e_pkg::TZ_W-1:0]    tz_reg, tz_next;
    logic [a2e_pkg::DAYS_W-1:0]         days_reg, days_next;
    logic signed [a2e_pkg::TOD_W-1:0]   tod_reg, tod_next;
    logic signed [a2e_pkg::EPOCH_W-1:0] prod_reg, prod_next;
    logic signed [a2e_pkg::EPOCH_W-1:0] epoch_reg;
    logic [a2e_pkg::MILLI_W-1:0]        millis_reg;
    logic                               valid_res_reg;

    logic [a2e_pkg::YEAR_W-1:0]     year_base;
    logic [FW-1:0]                  mon_dec;
    logic [a2e_pkg::RECIP12_W-1:0]  mq_prod;
    logic [a2e_pkg::ROW_W-1:0]      mq;
    logic [FW-1:0]                  mr;
    logic                           month_zero;
    logic [a2e_pkg::ROW_W-1:0]      row;
    logic                           prev_year;
    logic [a2e_pkg::RECIP100_W-1:0] p100;
    logic [a2e_pkg::TODP_W-1:0]     oh_sec;
    logic [a2e_pkg::TODP_W-1:0]     om_sec;
    logic [a2e_pkg::DAYS_W-1:0]     day_sum;
    logic signed [a2e_pkg::EPOCH_W-1:0] days_ext;

    // character class; low nibble of an ascii digit is its value
    assign digit           = char_byte[a2e_pkg::DIGIT_W-1:0];
    assign status.is_digit = (char_byte >= a2e_pkg::CH_0) && (char_byte <= a2e_pkg::CH_9);
    assign status.is_zulu  = (char_byte == a2e_pkg::CH_ZULU);
    assign status.is_plus  = (char_byte == a2e_pkg::CH_PLUS);
    assign status.is_minus = (char_byte == a2e_pkg::CH_MINUS);
    assign status.is_dot   = (char_byte == a2e_pkg::CH_DOT);

    // field folding
    always_ff @(posedge aclk) begin
        unique case (cmd.fld)
            a2e_pkg::FLD_NONE: ;
            a2e_pkg::FLD_YEAR_INIT: begin
                year_reg   <= a2e_pkg::YEAR_W'(digit);
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
                milli_reg  <= '0;
                neg_reg    <= 1'b0;
                oh_reg     <= '0;
                om_reg     <= '0;
            end
            a2e_pkg::FLD_YEAR_ACC:
                year_reg <= (year_reg << 3) + (year_reg << 1) + a2e_pkg::YEAR_W'(digit);
            a2e_pkg::FLD_MON_HI:  month_reg  <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_MON_LO:  month_reg  <= month_reg + FW'(digit);
            a2e_pkg::FLD_DAY_HI:  day_reg    <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_DAY_LO:  day_reg    <= day_reg + FW'(digit);
            a2e_pkg::FLD_HOUR_HI: hour_reg   <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_HOUR_LO: hour_reg   <= hour_reg + FW'(digit);
            a2e_pkg::FLD_MIN_HI:  minute_reg <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_MIN_LO:  minute_reg <= minute_reg + FW'(digit);
            a2e_pkg::FLD_SEC_HI:  second_reg <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_SEC_LO:  second_reg <= second_reg + FW'(digit);
            a2e_pkg::FLD_MS_INIT: milli_reg  <= a2e_pkg::MILLI_W'(digit);
            a2e_pkg::FLD_MS_ACC:
                milli_reg <= (milli_reg << 3) + (milli_reg << 1) + a2e_pkg::MILLI_W'(digit);
            a2e_pkg::FLD_SIGN:    neg_reg    <= status.is_minus;
            a2e_pkg::FLD_OH_HI:   oh_reg     <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_OH_LO:   oh_reg     <= oh_reg + FW'(digit);
            a2e_pkg::FLD_OM_HI:   om_reg     <= a2e_pkg::times_ten(digit);
            a2e_pkg::FLD_OM_LO:   om_reg     <= om_reg + FW'(digit);
            default: ;
        endcase
    end

    // step 1: full year, month folded into the year, march-based year, day of year and time of day
    always_comb begin
        if (cmd.kind_gen) begin
            year_base = year_reg;
        end else if (year_reg < a2e_pkg::UTC_PIVOT) begin
            year_base = year_reg + a2e_pkg::CENTURY_20;
        end else begin
            year_base = year_reg + a2e_pkg::CENTURY_19;
        end
        mon_dec    = month_reg - FW'(1);
        mq_prod    = a2e_pkg::RECIP12_W'(mon_dec) * a2e_pkg::RECIP_12;
        mq         = mq_prod[a2e_pkg::RECIP12_SHIFT +: a2e_pkg::ROW_W];
        mr         = mon_dec - ((FW'(mq) << 3) + (FW'(mq) << 2));
        month_zero = (month_reg == '0);
        row        = month_zero ? a2e_pkg::ROW_W'(11) : mr[a2e_pkg::ROW_W-1:0];
        prev_year  = !month_zero && (row < a2e_pkg::ROW_W'(2));
        y_next     = year_base + a2e_pkg::YEAR_BIAS
                   + (month_zero ? '0 : a2e_pkg::YEAR_W'(mq))
                   - a2e_pkg::YEAR_W'(month_zero || prev_year);
        doy_next   = a2e_pkg::month_doy(row);
        tod_pos_next = a2e_pkg::TODP_W'(hour_reg) * a2e_pkg::SEC_PER_HOUR
                     + a2e_pkg::TODP_W'(minute_reg) * a2e_pkg::SEC_PER_MIN
                     + a2e_pkg::TODP_W'(second_reg);
    end

    // step 2: centuries and zone offset
    always_comb begin
        p100      = a2e_pkg::RECIP100_W'(y_reg) * a2e_pkg::RECIP_100;
        q100_next = p100[a2e_pkg::RECIP100_SHIFT +: a2e_pkg::Q100_W];
        oh_sec    = a2e_pkg::TODP_W'(oh_reg) * a2e_pkg::SEC_PER_HOUR;
        om_sec    = a2e_pkg::TODP_W'(om_reg) * a2e_pkg::SEC_PER_MIN;
        // offset minutes always come off, whatever the sign
        tz_next   = (neg_reg ? $signed(a2e_pkg::TZ_W'(oh_sec))
                             : -$signed(a2e_pkg::TZ_W'(oh_sec)))
                  - $signed(a2e_pkg::TZ_W'(om_sec));
    end

    // step 3: day count and time of day
    always_comb begin
        day_sum   = a2e_pkg::DAYS_W'(y_reg) * a2e_pkg::DAYS_PER_YEAR
                  + a2e_pkg::DAYS_W'(y_reg >> 2)
                  + a2e_pkg::DAYS_W'(q100_reg >> 2)
                  + a2e_pkg::DAYS_W'(doy_reg)
                  + a2e_pkg::DAYS_W'(day_reg);
        days_next = day_sum - a2e_pkg::DAYS_W'(q100_reg) - a2e_pkg::DAYS_BIAS;
        tod_next  = $signed(a2e_pkg::TOD_W'(tod_pos_reg)) + a2e_pkg::TOD_W'(tz_reg);
    end

    // step 4: days to seconds
    assign days_ext  = a2e_pkg::EPOCH_W'($signed(days_reg));
    assign prod_next = days_ext * a2e_pkg::SEC_PER_DAY;

    always_ff @(posedge aclk) begin
        if (cmd.cv1) begin
            y_reg       <= y_next;
            doy_reg     <= doy_next;
            tod_pos_reg <= tod_pos_next;
        end
        if (cmd.cv2) begin
            q100_reg <= q100_next;
            tz_reg   <= tz_next;
        end
        if (cmd.cv3) begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
        if (cmd.cv4) begin
            prod_reg <= prod_next;
        end
        // output word: final add, or all zeros for a rejected string
        if (cmd.out_load) begin
            if (cmd.out_ok) begin
                epoch_reg     <= prod_reg + a2e_pkg::EPOCH_W'(tod_reg);
                millis_reg    <= milli_reg;
                valid_res_reg <= 1'b1;
            end else begin
                epoch_reg     <= '0;
                millis_reg    <= '0;
                valid_res_reg <= 1'b0;
            end
        end
    end

    assign epoch_seconds = epoch_reg;
    assign millis        = millis_reg;
    assign valid_res     = valid_res_reg;

endmodule

`default_nettype wire

// ----- rtl/a2e_checker.sv -----
`default_nettype none

`include "asn1_time_to_epoch_parser_defines.svh"

module a2e_checker (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    input  wire                           s_tready,
    input  wire [a2e_pkg::CHAR_W-1:0]     s_tdata,
    input  wire [a2e_pkg::KIND_W-1:0]     s_tuser,
    input  wire                           s_tlast,
    input  wire                           m_tvalid,
    input  wire                           m_tready,
    input  wire [a2e_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire [0:0]                     m_tuser
);

    // rejected string gives an all-zero word
    `A2E_ASSERT_NOW(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "rejected result carries nonzero data")

    // fraction never exceeds three digits
    `A2E_ASSERT_NOW(a_millis_range, aclk, aresetn, m_tvalid, m_tdata[a2e_pkg::EPOCH_W +: a2e_pkg::MILLI_W] <= a2e_pkg::MILLI_MAX, "millis out of range")

    // no character taken while a result word is stalled
    `A2E_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input accepted while result stalled")

    // stalled result word holds
    `A2E_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // waiting input word holds until taken
    `A2E_ASSERT_NEXT(a_input_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser) && $stable(s_tlast), "waiting input changed")

endmodule

bind asn1_time_to_epoch_parser a2e_checker u_a2e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
